/* sv/assert_macros.svh */
// assertion macros shared by the coalescer rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* sv/cbc_pkg.sv */
// types and register codes for the contiguous block coalescer
// no dependencies; imported by every module and interface of the block
`timescale 1ns / 1ps

package cbc_pkg;

  localparam logic [1:0] CFG_EXTENT    = 2'd0;
  localparam logic [1:0] CFG_SIZE      = 2'd1;
  localparam logic [1:0] CFG_BYTE_MODE = 2'd2;

  typedef logic [31:0]        len_t;
  typedef logic signed [47:0] disp_t;
  typedef logic [62:0]        run_len_t;
  typedef logic signed [63:0] run_off_t;

  typedef struct packed {
    logic [31:0] extent;
    logic        size_nz;
    logic        byte_mode;
  } cbc_cfg_t;

  // one pending result; offset is scaled on the way out
  typedef struct packed {
    run_len_t    len;
    logic [63:0] start;
    logic [31:0] ext;
    logic        byte_mode;
    logic        last;
    logic        empty;
  } cbc_entry_t;

  typedef struct packed {
    logic       wr_a;
    logic       wr_b;
    cbc_entry_t ent_a;
    cbc_entry_t ent_b;
  } cbc_push_t;

endpackage

/* sv/cbc_if.sv */
// descriptor and result channel interfaces, valid/ready handshake
// depends on cbc_pkg for payload types
`timescale 1ns / 1ps

interface cbc_in_if;
  import cbc_pkg::*;
  logic  valid;
  logic  ready;
  len_t  block_length;
  disp_t displacement;
  logic  last_block;

  modport source (output valid, block_length, displacement, last_block, input ready);
  modport sink (input valid, block_length, displacement, last_block, output ready);
endinterface

interface cbc_out_if;
  import cbc_pkg::*;
  logic     valid;
  logic     ready;
  run_len_t run_length;
  run_off_t run_offset;
  logic     last_run;
  logic     empty_list;

  modport source (output valid, run_length, run_offset, last_run, empty_list, input ready);
  modport sink (input valid, run_length, run_offset, last_run, empty_list, output ready);
endinterface

/* sv/cbc_merge.sv */
// descriptor register, run tracking state and result generation
// depends on cbc_pkg and cbc_in_if
`timescale 1ns / 1ps

module cbc_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  cbc_pkg::cbc_cfg_t cfg,
  cbc_in_if.sink            in_ch,
  input  logic              q_room,
  output cbc_pkg::cbc_push_t push
);
  import cbc_pkg::*;

  logic        va_r, va_nxt;
  len_t        len_r;
  logic [63:0] disp_r;
  logic        last_r;
  logic [63:0] span_r, span_nxt;

  logic        open_r, open_nxt;
  logic [63:0] start_r, start_nxt;
  logic [63:0] count_r, count_nxt;
  logic [63:0] end_r, end_nxt;

  logic        accept, adv;
  logic        len_nz, contig, emit0;
  logic        open_p;
  logic [63:0] start_p, count_p, end_p;
  cbc_entry_t  e0, e1;

  assign adv          = va_r && q_room;
  assign in_ch.ready  = !va_r || adv;
  assign accept       = in_ch.valid && in_ch.ready;

  // span of a block in displacement units
  assign span_nxt = cfg.byte_mode ? (64'(in_ch.block_length) * 64'(cfg.extent))
                                  : 64'(in_ch.block_length);

  always_comb begin
    va_nxt = va_r;
    if (accept) begin
      va_nxt = 1'b1;
    end else if (adv) begin
      va_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      len_r  <= in_ch.block_length;
      disp_r <= 64'(in_ch.displacement);
      last_r <= in_ch.last_block;
      span_r <= span_nxt;
    end
  end

  assign len_nz = (len_r != '0);
  assign contig = open_r && (end_r == disp_r);
  assign emit0  = len_nz && !contig && open_r && cfg.size_nz;

  always_comb begin
    open_p  = open_r;
    start_p = start_r;
    count_p = count_r;
    end_p   = end_r;
    if (len_nz) begin
      open_p = 1'b1;
      if (contig) begin
        count_p = count_r + 64'(len_r);
        end_p   = end_r + span_r;
      end else begin
        start_p = disp_r;
        count_p = 64'(len_r);
        end_p   = disp_r + span_r;
      end
    end
  end

  always_comb begin
    e0.len       = count_r[62:0];
    e0.start     = start_r;
    e0.ext       = cfg.extent;
    e0.byte_mode = cfg.byte_mode;
    e0.last      = 1'b0;
    e0.empty     = 1'b0;
    if (open_p && cfg.size_nz) begin
      e1.len       = count_p[62:0];
      e1.start     = start_p;
      e1.ext       = cfg.extent;
      e1.byte_mode = cfg.byte_mode;
      e1.empty     = 1'b0;
    end else begin
      // empty list: byte mode passes the zero start straight through
      e1.len       = '0;
      e1.start     = '0;
      e1.ext       = cfg.extent;
      e1.byte_mode = 1'b1;
      e1.empty     = 1'b1;
    end
    e1.last = 1'b1;
  end

  always_comb begin
    push.wr_a  = adv && (emit0 || last_r);
    push.wr_b  = adv && emit0 && last_r;
    push.ent_a = emit0 ? e0 : e1;
    push.ent_b = e1;
  end

  always_comb begin
    open_nxt  = open_r;
    start_nxt = start_r;
    count_nxt = count_r;
    end_nxt   = end_r;
    if (adv) begin
      if (last_r) begin
        open_nxt  = 1'b0;
        start_nxt = '0;
        count_nxt = '0;
        end_nxt   = '0;
      end else begin
        open_nxt  = open_p;
        start_nxt = start_p;
        count_nxt = count_p;
        end_nxt   = end_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      start_r <= '0;
      count_r <= '0;
      end_r   <= '0;
    end else begin
      open_r  <= open_nxt;
      start_r <= start_nxt;
      count_r <= count_nxt;
      end_r   <= end_nxt;
    end
  end

endmodule

/* sv/cbc_outq.sv */
// result queue and output register with byte offset scaling
// depends on cbc_pkg, cbc_out_if and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbc_outq #(
  parameter int QDEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cbc_pkg::cbc_push_t push,
  output logic               q_room,
  cbc_out_if.source          out_ch
);
  import cbc_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cbc_entry_t q_r [QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_b;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic        ov_r, ov_nxt;
  run_len_t    len_r;
  run_off_t    off_r;
  logic        last_r, empty_r;

  logic        pop;
  cbc_entry_t  head;
  logic [63:0] lo_p, off_nxt;
  logic [31:0] hi_p;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // room for the worst case of two results from one request
  assign q_room = (cnt_r <= CW'(QDEPTH - 2));
  assign pop    = (cnt_r != '0) && (!ov_r || out_ch.ready);
  assign head   = q_r[rp_r];
  assign wp_b   = ptr_inc(wp_r);

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push.wr_b) begin
      wp_nxt = ptr_inc(wp_b);
    end else if (push.wr_a) begin
      wp_nxt = wp_b;
    end
    if (pop) begin
      rp_nxt = ptr_inc(rp_r);
    end
    cnt_nxt = cnt_r + CW'(push.wr_a) + CW'(push.wr_b) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.wr_a) begin
      q_r[wp_r] <= push.ent_a;
    end
    if (push.wr_b) begin
      q_r[wp_b] <= push.ent_b;
    end
  end

  // start * extent mod 2^64 from two 32x32 partial products
  assign lo_p    = 64'(head.start[31:0]) * 64'(head.ext);
  assign hi_p    = head.start[63:32] * head.ext;
  assign off_nxt = head.byte_mode ? head.start : (lo_p + {hi_p, 32'b0});

  always_comb begin
    ov_nxt = ov_r;
    if (pop) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      len_r   <= head.len;
      off_r   <= off_nxt;
      last_r  <= head.last;
      empty_r <= head.empty;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.run_length = len_r;
  assign out_ch.run_offset = off_r;
  assign out_ch.last_run   = last_r;
  assign out_ch.empty_list = empty_r;

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CW'(QDEPTH), "result queue overflow")
  `ASSERT_IMPLIES(a_two_fit, clk, rst_n, push.wr_b, push.wr_a && q_room, "double push without room")
  `ASSERT_IMPLIES(a_empty_zero, clk, rst_n, ov_r && empty_r,
    last_r && (len_r == '0) && (off_r == '0), "empty list result carries data")

endmodule

/* sv/contiguous_block_coalescer_core.sv */
// top level of the contiguous block coalescer: config registers, merge and result queue
// depends on cbc_pkg, cbc_if, cbc_merge and cbc_outq
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    block_length, displacement, last_block
//   out_ch   out  valid/ready    run_length, run_offset, last_run, empty_list
//   cfg_*    in   write enable   cfg_index, cfg_data
//
// one descriptor per cycle while the queue has room; a descriptor passes through the
// descriptor register, then the queue write, then the output register when it is free
// a descriptor may yield two results; the output drains one per cycle while ready, so
// that sequence holds the input once the queue cannot take two more
// reset is synchronous and active low; it restores the register defaults and
// closes any open run
`timescale 1ns / 1ps

module contiguous_block_coalescer_core #(
  parameter int QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  cbc_in_if.sink      in_ch,
  cbc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cbc_pkg::*;

  logic [31:0] element_extent_r;
  logic [31:0] element_size_r;
  logic        disp_in_bytes_r;

  cbc_cfg_t  cfg;
  cbc_push_t push;
  logic      q_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_extent_r <= 32'd1;
      element_size_r   <= 32'd1;
      disp_in_bytes_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXTENT:    element_extent_r <= cfg_data;
        CFG_SIZE:      element_size_r   <= cfg_data;
        CFG_BYTE_MODE: disp_in_bytes_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.extent    = element_extent_r;
  assign cfg.size_nz   = (element_size_r != '0);
  assign cfg.byte_mode = disp_in_bytes_r;

  cbc_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_room (q_room),
    .push   (push)
  );

  cbc_outq #(
    .QDEPTH (QDEPTH)
  ) u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_room (q_room),
    .out_ch (out_ch)
  );

endmodule

/* tb/cbc_checker.sv */
// run checker for the contiguous block coalescer: tracks register writes,
// predicts the merged runs of every accepted request and compares them in order
// depends on cbc_pkg and the channel interfaces in cbc_if
`timescale 1ns / 1ps

module cbc_checker (
  input  logic        clk,
  input  logic        rst_n,
  cbc_in_if           in_mon,
  cbc_out_if          out_mon,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          runs_pending
);
  import cbc_pkg::*;

  typedef struct packed {
    run_len_t len;
    run_off_t off;
    logic     is_last;
    logic     is_empty;
  } run_rec_t;

  run_rec_t    run_q[$];
  run_rec_t    seen_run;
  logic [31:0] extent;
  logic [31:0] elem_size;
  logic        byte_mode;
  logic        run_live;
  logic [63:0] start_pos;
  logic [63:0] elem_count;
  logic [63:0] end_pos;
  int          bad;

  task automatic close_run(input logic is_last);
    run_rec_t r;
    r.len      = elem_count[62:0];
    r.off      = byte_mode ? start_pos : start_pos * {32'd0, extent};
    r.is_last  = is_last;
    r.is_empty = 1'b0;
    run_q.push_back(r);
  endtask

  task automatic clear_run();
    run_live   = 1'b0;
    start_pos  = '0;
    elem_count = '0;
    end_pos    = '0;
  endtask

  task automatic coalesce(input len_t blen, input disp_t bdisp, input logic blast);
    logic [63:0] d64;
    logic [63:0] span;
    run_rec_t    e;
    d64  = {{16{bdisp[47]}}, bdisp};
    span = byte_mode ? {32'd0, blen} * {32'd0, extent} : {32'd0, blen};
    if (blen != 0) begin
      if (run_live && end_pos == d64) begin
        elem_count += {32'd0, blen};
        end_pos    += span;
      end else begin
        if (run_live && elem_size != 0) close_run(1'b0);
        run_live   = 1'b1;
        start_pos  = d64;
        elem_count = {32'd0, blen};
        end_pos    = d64 + span;
      end
    end
    if (blast) begin
      if (run_live && elem_size != 0) begin
        close_run(1'b1);
      end else begin
        e          = '0;
        e.is_last  = 1'b1;
        e.is_empty = 1'b1;
        run_q.push_back(e);
      end
      clear_run();
    end
  endtask

  task automatic check_run(input run_rec_t got);
    run_rec_t want;
    if (run_q.size() == 0) begin
      bad++;
      if (bad <= 10)
        $display("%0t: unexpected run len=%0d off=%0d last=%0b empty=%0b", $realtime,
                 got.len, got.off, got.is_last, got.is_empty);
    end else begin
      want = run_q.pop_front();
      if (got.len !== want.len || got.off !== want.off ||
          got.is_last !== want.is_last || got.is_empty !== want.is_empty) begin
        bad++;
        if (bad <= 10)
          $display("%0t: run mismatch expected len=%0d off=%0d last=%0b empty=%0b, %s%0d %s%0d %s%0b %s%0b",
                   $realtime, want.len, want.off, want.is_last, want.is_empty,
                   "got len=", got.len, "off=", got.off, "last=", got.is_last,
                   "empty=", got.is_empty);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      extent    = 32'd1;
      elem_size = 32'd1;
      byte_mode = 1'b0;
      clear_run();
      run_q.delete();
      bad = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_EXTENT:    extent    = cfg_data;
          CFG_SIZE:      elem_size = cfg_data;
          CFG_BYTE_MODE: byte_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        coalesce(in_mon.block_length, in_mon.displacement, in_mon.last_block);
      if (out_mon.valid && out_mon.ready) begin
        seen_run.len      = out_mon.run_length;
        seen_run.off      = out_mon.run_offset;
        seen_run.is_last  = out_mon.last_run;
        seen_run.is_empty = out_mon.empty_list;
        check_run(seen_run);
      end
    end
    mismatches   <= bad;
    runs_pending <= run_q.size();
  end

endmodule

/* tb/tb_top.sv */
// testbench top for the contiguous block coalescer: clock, reset, register
// programming, descriptor lists and random output stalls; verdict from cbc_checker
// depends on cbc_pkg, cbc_if, cbc_checker and contiguous_block_coalescer_core
`timescale 1ns / 1ps

module tb_top;
  import cbc_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 205;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          idle_pct;
  int          stall_pct;
  int          mismatches;
  int          runs_pending;
  int          quiet_cycles;
  int          sent_items;

  // stimulus-side view of where the open run ends, used to build contiguous lists
  logic [31:0] cur_ext;
  logic        cur_mode;
  logic [63:0] tail;
  logic        tail_ok;

  cbc_in_if  in_ch ();
  cbc_out_if out_ch ();

  contiguous_block_coalescer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cbc_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .runs_pending (runs_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_desc(input len_t l, input disp_t d, input logic lb);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.block_length <= l;
    in_ch.displacement <= d;
    in_ch.last_block   <= lb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (l != 0) begin
      tail = {{16{d[47]}}, d} + (cur_mode ? {32'd0, l} * {32'd0, cur_ext} : {32'd0, l});
      tail_ok = 1'b1;
    end
    if (lb) tail_ok = 1'b0;
    sent_items++;
  endtask

  // hold requests until every predicted run is out and the pipe has drained
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (runs_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] ext, input logic [31:0] size,
                              input logic mode);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EXTENT;
    cfg_data  <= ext;
    @(posedge clk);
    cfg_index <= CFG_SIZE;
    cfg_data  <= size;
    @(posedge clk);
    cfg_index <= CFG_BYTE_MODE;
    cfg_data  <= {31'd0, mode};
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_ext  = ext;
    cur_mode = mode;
  endtask

  function automatic disp_t any_disp();
    disp_t       d;
    int          v;
    logic [63:0] w;
    case ($urandom_range(3))
      0: begin
        v = int'($urandom_range(2000)) - 1000;
        d = 48'(v);
      end
      1: begin
        w = {$urandom, $urandom};
        d = w[47:0];
      end
      2: begin
        case ($urandom_range(3))
          0: d = 48'sh7FFF_FFFF_FFFF;
          1: d = 48'sh8000_0000_0000;
          2: d = -48'sd1;
          default: d = '0;
        endcase
      end
      default: d = 48'($urandom_range(100000));
    endcase
    return d;
  endfunction

  function automatic len_t any_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(1, 64);
    if (r < 92) return $urandom;
    return 32'hFFFF_FFFF;
  endfunction

  // mostly contiguous lists with random content, some skips and jumps
  task automatic random_list();
    int    n;
    int    r;
    len_t  l;
    disp_t d;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      l = (r < 8) ? '0 : any_len();
      if (r >= 8 && r < 72 && tail_ok && tail[63:47] == {17{tail[47]}})
        d = tail[47:0];
      else
        d = any_disp();
      send_desc(l, d, i == n - 1);
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_EXTENT;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.block_length <= '0;
    in_ch.displacement <= '0;
    in_ch.last_block   <= 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    sent_items = 0;
    cur_ext    = 32'd1;
    cur_mode   = 1'b0;
    tail       = '0;
    tail_ok    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    program_regs(32'd1, 32'd1, 1'b0);
    send_desc(32'd0, 48'sd0, 1'b1);                       // empty list
    send_desc(32'hFFFF_FFFF, 48'sh8000_0000_0000, 1'b0);
    send_desc(32'hFFFF_FFFF, 48'sh8000_FFFF_FFFF, 1'b0);  // joins the open run
    send_desc(32'd0, 48'sd5, 1'b0);                       // zero length skipped
    send_desc(32'd3, 48'sh7FFF_FFFF_FFFF, 1'b0);          // gap closes a run
    send_desc(32'd0, 48'sd0, 1'b1);                       // zero length flush
    send_desc(32'd1, -48'sd1, 1'b0);
    send_desc(32'd2, 48'sd0, 1'b1);
    send_desc(32'd4, 48'sd100, 1'b1);
    send_desc(32'd4, 48'sd100, 1'b0);
    send_desc(32'd4, 48'sd100, 1'b1);                     // two runs from one request

    program_regs(32'hFFFF_FFFF, 32'd0, 1'b1);             // zero size empties list
    send_desc(32'd7, 48'sd10, 1'b0);
    send_desc(32'd5, 48'sd99, 1'b0);
    send_desc(32'd1, 48'sd3, 1'b1);

    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_desc(32'hFFFF_FFFF, 48'sd0, 1'b0);
    send_desc(32'd2, 48'sd5, 1'b0);
    send_desc(32'd1, 48'sh1_0000_0003, 1'b1);             // byte-mode gap, two runs from one request

    program_regs(32'd0, 32'd1, 1'b1);                     // zero extent in byte mode
    send_desc(32'd5, 48'sd20, 1'b0);
    send_desc(32'd6, 48'sd20, 1'b1);

    program_regs(32'd2, 32'd1, 1'b0);
    send_desc(32'd3, 48'sh7FFF_FFFF_FFFF, 1'b1);
    send_desc(32'd1, 48'sh8000_0000_0000, 1'b1);

    sent_items = 0;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: program_regs(32'd1, 32'd1, 1'b0);
        1: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        2: program_regs(32'd0, 32'd0, 1'b0);
        3: program_regs($urandom_range(1, 64), $urandom, 1'b1);
        4: program_regs($urandom, 32'd1, 1'b0);
        5: program_regs(32'd0, 32'd5, 1'b1);
        6: program_regs(32'd8, 32'd0, 1'b1);
        default: program_regs($urandom, $urandom, 1'($urandom_range(1)));
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      while (sent_items < (p + 1) * PHASE_ITEMS) random_list();
    end

    settle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
